### src/ppou_pkg.sv
// ----------------------------------------------------------------------------
// ppou_pkg
// types and constants shared by the planar pose odometry update core
// ----------------------------------------------------------------------------
package ppou_pkg;

  localparam int ANGLE_BITS = 16;
  localparam int POS_W      = 32;
  localparam int TIME_W     = 48;
  localparam int DT_W       = 32;

  // rotator datapath
  localparam int ZA_W       = 32;
  localparam int PROD_W     = 64;
  localparam int PRESHIFT   = 14;
  localparam int XW         = 50;
  localparam int ZW         = 34;
  localparam int GUARD      = 16;
  localparam int ATAN_N     = 24;

  localparam logic signed [31:0] GAIN_Q30 = 32'sd652032874;

  localparam logic [31:0] ATAN_TAB [ATAN_N] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
    32'd42667331,  32'd21354465,  32'd10680862,  32'd5340245,
    32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
    32'd166886,    32'd83443,     32'd41721,     32'd20860,
    32'd10430,     32'd5215,      32'd2607,      32'd1303,
    32'd651,       32'd325,       32'd162,       32'd81
  };

  typedef struct packed {
    logic signed [POS_W-1:0]      prev_x;
    logic signed [POS_W-1:0]      prev_y;
    logic signed [ANGLE_BITS-1:0] prev_heading;
    logic        [TIME_W-1:0]     prev_time;
    logic signed [POS_W-1:0]      step_dx;
    logic signed [POS_W-1:0]      step_dy;
    logic signed [ANGLE_BITS-1:0] step_dheading;
    logic        [DT_W-1:0]       step_dt;
  } pose_in_t;

  typedef struct packed {
    logic signed [POS_W-1:0]      new_x;
    logic signed [POS_W-1:0]      new_y;
    logic signed [ANGLE_BITS-1:0] new_heading;
    logic        [TIME_W-1:0]     new_time;
  } pose_out_t;

  // fields carried alongside the rotator
  typedef struct packed {
    logic signed [POS_W-1:0]      px;
    logic signed [POS_W-1:0]      py;
    logic signed [ANGLE_BITS-1:0] heading;
    logic        [TIME_W-1:0]     time_sum;
  } side_t;

  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
  } rot_t;

endpackage

### src/ppou_cordic_stage.sv
// ----------------------------------------------------------------------------
// ppou_cordic_stage
// one registered micro-rotation of the rotation-mode cordic pipeline
// ----------------------------------------------------------------------------
module ppou_cordic_stage
  import ppou_pkg::*;
#(
  parameter int SHIFT = 0
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  en,
  input  logic  valid_in,
  input  rot_t  rot_in,
  input  side_t side_in,
  output logic  valid,
  output rot_t  rot_out,
  output side_t side_out
);

  logic signed [XW-1:0] xs;
  logic signed [XW-1:0] ys;
  logic signed [ZW-1:0] ang;
  rot_t                 rot_next;

  always_comb begin
    xs  = $signed(rot_in.x) >>> SHIFT;
    ys  = $signed(rot_in.y) >>> SHIFT;
    ang = $signed({{(ZW-32){1'b0}}, ATAN_TAB[SHIFT]});
    if (!rot_in.z[ZW-1]) begin
      rot_next.x = rot_in.x - ys;
      rot_next.y = rot_in.y + xs;
      rot_next.z = rot_in.z - ang;
    end else begin
      rot_next.x = rot_in.x + ys;
      rot_next.y = rot_in.y - xs;
      rot_next.z = rot_in.z + ang;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rot_out  <= rot_next;
      side_out <= side_in;
    end
  end

endmodule

### src/planar_pose_odometry_update_core.sv
// ----------------------------------------------------------------------------
// planar_pose_odometry_update_core
// composes a planar pose with one body-frame odometry increment
// ----------------------------------------------------------------------------
// input channel pose / pose_valid / pose_ready carries the previous pose and
// the increment; output channel result / result_valid / result_ready carries
// the composed pose, exactly one result per input transaction, in order.
// the increment is rotated by the previous heading in a fully pipelined
// rotation-mode cordic and added to the previous position with saturation;
// headings add modulo a full circle and time stamps add with saturation.
// the pipeline has one gain multiply stage, one quadrant fold stage, one
// cordic stage per micro-rotation and one round, add and saturate stage
// feeding the output register.
// throughput is one transaction per cycle while result_ready stays high, set
// by the one-rotation-per-stage cordic pipeline.
// every stage holds a valid bit; a stage loads whenever it is empty or the
// stage after it moves, so a stalled receiver only freezes the occupied
// stages at the end and bubbles ahead of them still fill.
// reset clears all valid bits; no result is pending after reset.
// ----------------------------------------------------------------------------
module planar_pose_odometry_update_core
  import ppou_pkg::*;
#(
  parameter int CORDIC_STAGES = 16
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      pose_valid,
  output logic      pose_ready,
  input  pose_in_t  pose,
  output logic      result_valid,
  input  logic      result_ready,
  output pose_out_t result
);

  localparam int NS = CORDIC_STAGES + 3;

  logic [NS-1:0] en;
  logic [NS-1:0] v;

  // stage 0: gain multiply, angle fold, heading and time sums
  logic signed [PROD_W-1:0]     prod_x;
  logic signed [PROD_W-1:0]     prod_y;
  logic                         flip;
  logic signed [ZA_W-1:0]       za0;
  side_t                        side0;

  logic [ZA_W-1:0]              za;
  logic [TIME_W:0]              tsum;
  logic signed [PROD_W-1:0]     prod_x_next;
  logic signed [PROD_W-1:0]     prod_y_next;
  side_t                        side0_next;
  logic [ZA_W-1:0]              za0_next;

  always_comb begin
    za = {pose.prev_heading, {(ZA_W-ANGLE_BITS){1'b0}}};
    prod_x_next = $signed(pose.step_dx) * GAIN_Q30;
    prod_y_next = $signed(pose.step_dy) * GAIN_Q30;
    za0_next = (za[ZA_W-1] ^ za[ZA_W-2]) ? {~za[ZA_W-1], za[ZA_W-2:0]} : za;
    tsum = {1'b0, pose.prev_time} + {{(TIME_W+1-DT_W){1'b0}}, pose.step_dt};
    side0_next.px = pose.prev_x;
    side0_next.py = pose.prev_y;
    side0_next.heading = pose.prev_heading + pose.step_dheading;
    side0_next.time_sum = tsum[TIME_W] ? {TIME_W{1'b1}} : tsum[TIME_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      prod_x <= prod_x_next;
      prod_y <= prod_y_next;
      flip   <= za[ZA_W-1] ^ za[ZA_W-2];
      za0    <= $signed(za0_next);
      side0  <= side0_next;
    end
  end

  // stage 1: prescale shift and half-circle negation
  rot_t                 rot [CORDIC_STAGES+1];
  side_t                side [CORDIC_STAGES+1];
  rot_t                 rot1;
  side_t                side1;
  logic signed [XW-1:0] xp;
  logic signed [XW-1:0] yp;
  rot_t                 rot1_next;

  always_comb begin
    xp = $signed(prod_x[PRESHIFT+XW-1:PRESHIFT]);
    yp = $signed(prod_y[PRESHIFT+XW-1:PRESHIFT]);
    rot1_next.x = flip ? -xp : xp;
    rot1_next.y = flip ? -yp : yp;
    rot1_next.z = {{(ZW-ZA_W){za0[ZA_W-1]}}, za0};
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      rot1  <= rot1_next;
      side1 <= side0;
    end
  end

  assign rot[0]  = rot1;
  assign side[0] = side1;

  // cordic stages
  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
    ppou_cordic_stage #(
      .SHIFT(i)
    ) u_stage (
      .clk      (clk),
      .rst      (rst),
      .en       (en[i+2]),
      .valid_in (v[i+1]),
      .rot_in   (rot[i]),
      .side_in  (side[i]),
      .valid    (v[i+2]),
      .rot_out  (rot[i+1]),
      .side_out (side[i+1])
    );
  end

  // last stage: round, add to position, saturate
  localparam logic signed [XW-1:0] ROUND_C = XW'(1) <<< (GUARD - 1);
  localparam logic signed [XW-1:0] POS_MAX = XW'(64'sd2147483647);
  localparam logic signed [XW-1:0] POS_MIN = -(XW'(64'sd2147483648));

  logic signed [XW-1:0] rx;
  logic signed [XW-1:0] ry;
  logic signed [XW-1:0] sx;
  logic signed [XW-1:0] sy;
  pose_out_t            result_next;

  always_comb begin
    rx = ($signed(rot[CORDIC_STAGES].x) + ROUND_C) >>> GUARD;
    ry = ($signed(rot[CORDIC_STAGES].y) + ROUND_C) >>> GUARD;
    sx = rx + {{(XW-POS_W){side[CORDIC_STAGES].px[POS_W-1]}}, side[CORDIC_STAGES].px};
    sy = ry + {{(XW-POS_W){side[CORDIC_STAGES].py[POS_W-1]}}, side[CORDIC_STAGES].py};
    if (sx > POS_MAX) begin
      result_next.new_x = POS_MAX[POS_W-1:0];
    end else if (sx < POS_MIN) begin
      result_next.new_x = POS_MIN[POS_W-1:0];
    end else begin
      result_next.new_x = sx[POS_W-1:0];
    end
    if (sy > POS_MAX) begin
      result_next.new_y = POS_MAX[POS_W-1:0];
    end else if (sy < POS_MIN) begin
      result_next.new_y = POS_MIN[POS_W-1:0];
    end else begin
      result_next.new_y = sy[POS_W-1:0];
    end
    result_next.new_heading = side[CORDIC_STAGES].heading;
    result_next.new_time = side[CORDIC_STAGES].time_sum;
  end

  always_ff @(posedge clk) begin
    if (en[NS-1]) begin
      result <= result_next;
    end
  end

  // valid bits for the stages outside the cordic chain
  logic v_in;
  logic v_rot;
  logic v_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      v_in  <= 1'b0;
      v_rot <= 1'b0;
      v_out <= 1'b0;
    end else begin
      if (en[0]) begin
        v_in <= pose_valid;
      end
      if (en[1]) begin
        v_rot <= v_in;
      end
      if (en[NS-1]) begin
        v_out <= v[NS-2];
      end
    end
  end

  assign v[0]    = v_in;
  assign v[1]    = v_rot;
  assign v[NS-1] = v_out;

  // a stage loads when empty or when its successor moves
  always_comb begin
    en[NS-1] = !v[NS-1] || result_ready;
    for (int k = NS - 2; k >= 0; k--) begin
      en[k] = !v[k] || en[k+1];
    end
  end

  assign pose_ready   = en[0];
  assign result_valid = v[NS-1];

endmodule
